/* src/mmts_pkg.sv */
package mmts_pkg;

    // Sizes of the token scanner
    localparam int KW_MAX_CHARS  = 7;
    localparam int KW_BITS       = 8 * KW_MAX_CHARS;
    localparam int LEN_BITS      = 16;
    localparam int OFF_BITS      = 32;
    localparam int VAL_BITS      = 31;
    localparam int KIND_BITS     = 6;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [VAL_BITS-1:0] NUM_MAX = {VAL_BITS{1'b1}};

    // DFA states
    typedef enum logic [3:0] {
        S_START   = 4'd0,
        S_ZERO    = 4'd1,
        S_NUMS    = 4'd2,
        S_SINGLE  = 4'd3,
        S_NEG     = 4'd4,
        S_COND1   = 4'd5,
        S_COND2   = 4'd6,
        S_IDKEY   = 4'd7,
        S_DIGIT   = 4'd8,
        S_WS      = 4'd9,
        S_SLASH   = 4'd10,
        S_COMMENT = 4'd11,
        S_FAIL    = 4'd15
    } t_dfa;

    // Token kinds
    localparam logic [KIND_BITS-1:0] K_ID      = 6'd0;
    localparam logic [KIND_BITS-1:0] K_NUM     = 6'd1;
    localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd2;
    localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd3;
    localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd4;
    localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd5;
    localparam logic [KIND_BITS-1:0] K_RETURN  = 6'd6;
    localparam logic [KIND_BITS-1:0] K_IF      = 6'd7;
    localparam logic [KIND_BITS-1:0] K_ELSE    = 6'd8;
    localparam logic [KIND_BITS-1:0] K_WHILE   = 6'd9;
    localparam logic [KIND_BITS-1:0] K_PRINTLN = 6'd10;
    localparam logic [KIND_BITS-1:0] K_WAIN    = 6'd11;
    localparam logic [KIND_BITS-1:0] K_BECOMES = 6'd12;
    localparam logic [KIND_BITS-1:0] K_INT     = 6'd13;
    localparam logic [KIND_BITS-1:0] K_EQ      = 6'd14;
    localparam logic [KIND_BITS-1:0] K_NE      = 6'd15;
    localparam logic [KIND_BITS-1:0] K_LT      = 6'd16;
    localparam logic [KIND_BITS-1:0] K_GT      = 6'd17;
    localparam logic [KIND_BITS-1:0] K_LE      = 6'd18;
    localparam logic [KIND_BITS-1:0] K_GE      = 6'd19;
    localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd20;
    localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd21;
    localparam logic [KIND_BITS-1:0] K_STAR    = 6'd22;
    localparam logic [KIND_BITS-1:0] K_SLASH   = 6'd23;
    localparam logic [KIND_BITS-1:0] K_PCT     = 6'd24;
    localparam logic [KIND_BITS-1:0] K_COMMA   = 6'd25;
    localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd26;
    localparam logic [KIND_BITS-1:0] K_NEW     = 6'd27;
    localparam logic [KIND_BITS-1:0] K_DELETE  = 6'd28;
    localparam logic [KIND_BITS-1:0] K_LBRACK  = 6'd29;
    localparam logic [KIND_BITS-1:0] K_RBRACK  = 6'd30;
    localparam logic [KIND_BITS-1:0] K_AMP     = 6'd31;
    localparam logic [KIND_BITS-1:0] K_NULL    = 6'd32;
    localparam logic [KIND_BITS-1:0] K_END     = 6'd33;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CHAR  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    // One result transaction
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [VAL_BITS-1:0]  value;
        logic [LEN_BITS-1:0]  length;
        logic [OFF_BITS-1:0]  start;
        logic [1:0]           err;
        logic                 last;
    } t_result;

    // Up to two results written into the output queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

/* src/mmts_finish.sv */
module mmts_finish (
    input  mmts_pkg::t_dfa                    i_state,
    input  logic [mmts_pkg::KW_BITS-1:0]      i_buf,
    input  logic [mmts_pkg::LEN_BITS-1:0]     i_cnt,
    input  logic [mmts_pkg::VAL_BITS-1:0]     i_acc,
    input  logic                              i_ovf,
    input  logic [mmts_pkg::OFF_BITS-1:0]     i_start,
    output logic                              o_valid,
    output mmts_pkg::t_result                 o_res
);

    localparam int NUM_KW = 10;

    // Keyword text, first byte in the low bits
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'h0000_0000_6E69_6177,   // wain
        64'h0000_0000_0074_6E69,   // int
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6573_6C65,   // else
        64'h0000_0065_6C69_6877,   // while
        64'h006E_6C74_6E69_7270,   // println
        64'h0000_6E72_7574_6572,   // return
        64'h0000_0000_4C4C_554E,   // NULL
        64'h0000_0000_0077_656E,   // new
        64'h0000_6574_656C_6564    // delete
    };
    localparam int KW_LEN [NUM_KW] = '{4, 3, 2, 4, 5, 7, 6, 4, 3, 6};
    localparam logic [mmts_pkg::KIND_BITS-1:0] KW_KIND [NUM_KW] = '{
        mmts_pkg::K_WAIN, mmts_pkg::K_INT, mmts_pkg::K_IF, mmts_pkg::K_ELSE,
        mmts_pkg::K_WHILE, mmts_pkg::K_PRINTLN, mmts_pkg::K_RETURN,
        mmts_pkg::K_NULL, mmts_pkg::K_NEW, mmts_pkg::K_DELETE
    };

    logic [7:0]                       c0;
    logic [mmts_pkg::KIND_BITS-1:0]   kw_kind;
    logic [mmts_pkg::KIND_BITS-1:0]   single_kind;

    assign c0 = i_buf[7:0];

    // Keyword lookup; lowest table entry wins
    always_comb begin
        kw_kind = mmts_pkg::K_ID;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            if (KW_LEN[i] <= mmts_pkg::KW_MAX_CHARS &&
                i_cnt == mmts_pkg::LEN_BITS'(KW_LEN[i]) &&
                i_buf == KW_TEXT[i][mmts_pkg::KW_BITS-1:0]) begin
                kw_kind = KW_KIND[i];
            end
        end
    end

    // Single-byte operator kinds
    always_comb begin
        case (c0)
            "(":     single_kind = mmts_pkg::K_LPAREN;
            ")":     single_kind = mmts_pkg::K_RPAREN;
            "{":     single_kind = mmts_pkg::K_LBRACE;
            "}":     single_kind = mmts_pkg::K_RBRACE;
            "+":     single_kind = mmts_pkg::K_PLUS;
            "-":     single_kind = mmts_pkg::K_MINUS;
            "*":     single_kind = mmts_pkg::K_STAR;
            "%":     single_kind = mmts_pkg::K_PCT;
            ";":     single_kind = mmts_pkg::K_SEMI;
            ",":     single_kind = mmts_pkg::K_COMMA;
            "[":     single_kind = mmts_pkg::K_LBRACK;
            "]":     single_kind = mmts_pkg::K_RBRACK;
            default: single_kind = mmts_pkg::K_AMP;
        endcase
    end

    // Turn the pending lexeme into a token, an error or nothing
    always_comb begin
        o_valid      = 1'b1;
        o_res.kind   = mmts_pkg::K_ID;
        o_res.value  = '0;
        o_res.length = i_cnt;
        o_res.start  = i_start;
        o_res.err    = mmts_pkg::ERR_NONE;
        o_res.last   = 1'b0;
        unique case (i_state)
            mmts_pkg::S_ZERO:   o_res.kind = mmts_pkg::K_NUM;
            mmts_pkg::S_NUMS: begin
                if (i_ovf) begin
                    o_res.err = mmts_pkg::ERR_RANGE;
                end else begin
                    o_res.kind  = mmts_pkg::K_NUM;
                    o_res.value = i_acc;
                end
            end
            mmts_pkg::S_IDKEY:  o_res.kind = kw_kind;
            mmts_pkg::S_DIGIT:  o_res.kind = mmts_pkg::K_ID;
            mmts_pkg::S_SINGLE: o_res.kind = single_kind;
            mmts_pkg::S_COND1: begin
                if (c0 == "=")      o_res.kind = mmts_pkg::K_BECOMES;
                else if (c0 == "<") o_res.kind = mmts_pkg::K_LT;
                else                o_res.kind = mmts_pkg::K_GT;
            end
            mmts_pkg::S_COND2: begin
                if (c0 == "=")      o_res.kind = mmts_pkg::K_EQ;
                else if (c0 == "<") o_res.kind = mmts_pkg::K_LE;
                else if (c0 == ">") o_res.kind = mmts_pkg::K_GE;
                else                o_res.kind = mmts_pkg::K_NE;
            end
            mmts_pkg::S_SLASH:  o_res.kind = mmts_pkg::K_SLASH;
            mmts_pkg::S_NEG:    o_res.err  = mmts_pkg::ERR_CHAR;
            default:            o_valid    = 1'b0;
        endcase
    end

endmodule

/* src/mmts_step.sv */
module mmts_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [7:0]           i_char,
    input  logic                 i_last,
    output mmts_pkg::t_push      o_push
);

    // Scanner state
    mmts_pkg::t_dfa                    r_dfa, n_dfa;
    logic [mmts_pkg::KW_BITS-1:0]      r_buf, n_buf;
    logic [mmts_pkg::LEN_BITS-1:0]     r_cnt, n_cnt;
    logic [mmts_pkg::VAL_BITS-1:0]     r_acc, n_acc;
    logic                              r_ovf, n_ovf;
    logic [mmts_pkg::OFF_BITS-1:0]     r_pos, n_pos;
    logic [mmts_pkg::OFF_BITS-1:0]     r_tstart, n_tstart;
    logic                              r_skip, n_skip;

    // Byte absorbed into the lexeme
    mmts_pkg::t_dfa                    dir_next, retry_next, a_dfa;
    logic                              restart, do_begin;
    logic [mmts_pkg::KW_BITS-1:0]      b_buf, a_buf;
    logic [mmts_pkg::LEN_BITS-1:0]     b_cnt, a_cnt;
    logic [mmts_pkg::VAL_BITS-1:0]     b_acc, a_acc;
    logic                              b_ovf, a_ovf;
    logic [mmts_pkg::OFF_BITS-1:0]     a_tstart, pos1;
    logic [34:0]                       acc_x10;

    logic                              fa_valid, fb_valid;
    mmts_pkg::t_result                 fa_res, fb_res;
    mmts_pkg::t_result                 end_res;

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_single(logic [7:0] c);
        logic r;
        case (c) inside
            "(", ")", "{", "}", "+", "-", "*", "%", ";", ",", "[", "]", "&": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // DFA transition
    function automatic mmts_pkg::t_dfa nxt(mmts_pkg::t_dfa s, logic [7:0] c);
        mmts_pkg::t_dfa r;
        r = mmts_pkg::S_FAIL;
        if (!c[7]) begin
            unique case (s) inside
                mmts_pkg::S_START: begin
                    if (c == "0")                           r = mmts_pkg::S_ZERO;
                    else if (is_digit(c))                   r = mmts_pkg::S_NUMS;
                    else if (is_letter(c))                  r = mmts_pkg::S_IDKEY;
                    else if (c == "!")                      r = mmts_pkg::S_NEG;
                    else if (c == "=" || c == "<" || c == ">") r = mmts_pkg::S_COND1;
                    else if (is_single(c))                  r = mmts_pkg::S_SINGLE;
                    else if (is_ws(c))                      r = mmts_pkg::S_WS;
                    else if (c == "/")                      r = mmts_pkg::S_SLASH;
                end
                mmts_pkg::S_NUMS: begin
                    if (is_digit(c)) r = mmts_pkg::S_NUMS;
                end
                mmts_pkg::S_IDKEY, mmts_pkg::S_DIGIT: begin
                    if (is_letter(c))     r = mmts_pkg::S_IDKEY;
                    else if (is_digit(c)) r = mmts_pkg::S_DIGIT;
                end
                mmts_pkg::S_NEG, mmts_pkg::S_COND1: begin
                    if (c == "=") r = mmts_pkg::S_COND2;
                end
                mmts_pkg::S_WS: begin
                    if (is_ws(c)) r = mmts_pkg::S_WS;
                end
                mmts_pkg::S_SLASH: begin
                    if (c == "/") r = mmts_pkg::S_COMMENT;
                end
                mmts_pkg::S_COMMENT: begin
                    if (c != 8'h0A) r = mmts_pkg::S_COMMENT;
                end
                default: r = mmts_pkg::S_FAIL;
            endcase
        end
        return r;
    endfunction

    function automatic mmts_pkg::t_result mk_err(logic [mmts_pkg::LEN_BITS-1:0] len,
                                                 logic [mmts_pkg::OFF_BITS-1:0] start);
        mmts_pkg::t_result r;
        r.kind   = mmts_pkg::K_ID;
        r.value  = '0;
        r.length = len;
        r.start  = start;
        r.err    = mmts_pkg::ERR_CHAR;
        r.last   = 1'b0;
        return r;
    endfunction

    assign pos1       = r_pos + 1'b1;
    assign dir_next   = nxt(r_dfa, i_char);
    assign retry_next = nxt(mmts_pkg::S_START, i_char);

    // Absorb the byte, starting a new lexeme where needed
    always_comb begin
        restart  = (dir_next == mmts_pkg::S_FAIL);
        a_dfa    = restart ? retry_next : dir_next;
        do_begin = restart || (r_dfa == mmts_pkg::S_START);
        b_buf    = do_begin ? '0 : r_buf;
        b_cnt    = do_begin ? '0 : r_cnt;
        b_acc    = do_begin ? '0 : r_acc;
        b_ovf    = do_begin ? 1'b0 : r_ovf;
        a_tstart = do_begin ? r_pos : r_tstart;

        a_buf = b_buf;
        for (int i = 0; i < mmts_pkg::KW_MAX_CHARS; i++) begin
            if (b_cnt == mmts_pkg::LEN_BITS'(i)) begin
                a_buf[8*i +: 8] = i_char;
            end
        end
        a_cnt = (b_cnt != '1) ? b_cnt + 1'b1 : b_cnt;

        acc_x10 = 35'({b_acc, 3'b000}) + 35'({b_acc, 1'b0}) + 35'(i_char[3:0]);
        a_acc   = b_acc;
        a_ovf   = b_ovf;
        if (a_dfa == mmts_pkg::S_NUMS) begin
            if (acc_x10 > 35'(mmts_pkg::NUM_MAX)) begin
                a_ovf = 1'b1;
                a_acc = mmts_pkg::NUM_MAX;
            end else begin
                a_acc = acc_x10[mmts_pkg::VAL_BITS-1:0];
            end
        end
    end

    // Token of the lexeme that the byte ends
    mmts_finish u_fin_cur (
        .i_state (r_dfa),
        .i_buf   (r_buf),
        .i_cnt   (r_cnt),
        .i_acc   (r_acc),
        .i_ovf   (r_ovf),
        .i_start (r_tstart),
        .o_valid (fa_valid),
        .o_res   (fa_res)
    );

    // Token of the lexeme closed by the last byte
    mmts_finish u_fin_end (
        .i_state (a_dfa),
        .i_buf   (a_buf),
        .i_cnt   (a_cnt),
        .i_acc   (a_acc),
        .i_ovf   (a_ovf),
        .i_start (a_tstart),
        .o_valid (fb_valid),
        .o_res   (fb_res)
    );

    always_comb begin
        end_res.kind   = mmts_pkg::K_END;
        end_res.value  = '0;
        end_res.length = '0;
        end_res.start  = pos1;
        end_res.err    = mmts_pkg::ERR_NONE;
        end_res.last   = 1'b1;
    end

    // One byte step: results and next state
    always_comb begin
        logic is_err;
        logic clear;
        is_err   = 1'b0;
        clear    = 1'b0;
        o_push   = '0;
        n_dfa    = r_dfa;
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_skip   = r_skip;

        if (i_go) begin
            n_pos = pos1;
            if (r_skip) begin
                if (i_last) begin
                    o_push.cnt = 2'd1;
                    o_push.r0  = end_res;
                    clear      = 1'b1;
                end
            end else if (restart && r_dfa == mmts_pkg::S_START) begin
                o_push.cnt = 2'd1;
                o_push.r0  = mk_err(mmts_pkg::LEN_BITS'(1), r_pos);
                is_err     = 1'b1;
            end else if (restart && r_dfa == mmts_pkg::S_NEG) begin
                o_push.cnt = 2'd1;
                o_push.r0  = mk_err((r_cnt != '1) ? r_cnt + 1'b1 : r_cnt, r_tstart);
                is_err     = 1'b1;
            end else if (restart && fa_valid && fa_res.err != mmts_pkg::ERR_NONE) begin
                o_push.cnt = 2'd1;
                o_push.r0  = fa_res;
                is_err     = 1'b1;
            end else if (restart && retry_next == mmts_pkg::S_FAIL) begin
                // token then a bad byte
                is_err = 1'b1;
                if (fa_valid) begin
                    o_push.cnt = 2'd2;
                    o_push.r0  = fa_res;
                    o_push.r1  = mk_err(mmts_pkg::LEN_BITS'(1), r_pos);
                end else begin
                    o_push.cnt = 2'd1;
                    o_push.r0  = mk_err(mmts_pkg::LEN_BITS'(1), r_pos);
                end
            end else begin
                n_dfa    = a_dfa;
                n_buf    = a_buf;
                n_cnt    = a_cnt;
                n_acc    = a_acc;
                n_ovf    = a_ovf;
                n_tstart = a_tstart;
                if (restart && fa_valid) begin
                    o_push.cnt = 2'd1;
                    o_push.r0  = fa_res;
                end
                if (i_last) begin
                    clear = 1'b1;
                    if (o_push.cnt == 2'd1) begin
                        o_push.cnt = 2'd2;
                        o_push.r1  = fb_valid ? fb_res : end_res;
                        o_push.r1.last = 1'b1;
                    end else begin
                        o_push.cnt = 2'd1;
                        o_push.r0  = fb_valid ? fb_res : end_res;
                        o_push.r0.last = 1'b1;
                    end
                end
            end

            // error: flag the final result and skip to the last byte
            if (is_err) begin
                n_skip = 1'b1;
                if (i_last) begin
                    clear = 1'b1;
                    if (o_push.cnt == 2'd2) o_push.r1.last = 1'b1;
                    else                    o_push.r0.last = 1'b1;
                end
            end

            if (clear) begin
                n_dfa    = mmts_pkg::S_START;
                n_buf    = '0;
                n_cnt    = '0;
                n_acc    = '0;
                n_ovf    = 1'b0;
                n_pos    = '0;
                n_tstart = '0;
                n_skip   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dfa    <= mmts_pkg::S_START;
            r_buf    <= '0;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_pos    <= '0;
            r_tstart <= '0;
            r_skip   <= 1'b0;
        end else begin
            r_dfa    <= n_dfa;
            r_buf    <= n_buf;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_skip   <= n_skip;
        end
    end

endmodule

/* src/mmts_res_fifo.sv */
module mmts_res_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mmts_pkg::t_push      i_push,
    output logic                 o_room2,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mmts_pkg::t_result    o_res
);

    mmts_pkg::t_result                      r_mem [mmts_pkg::FIFO_DEPTH];
    logic [mmts_pkg::FIFO_PTR_BITS-1:0]     r_wp, n_wp;
    logic [mmts_pkg::FIFO_PTR_BITS-1:0]     r_rp, n_rp;
    logic [mmts_pkg::FIFO_CNT_BITS-1:0]     r_cnt, n_cnt;
    logic [mmts_pkg::FIFO_PTR_BITS-1:0]     wp1;
    logic                                   pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    assign o_room2 = (r_cnt <= mmts_pkg::FIFO_CNT_BITS'(mmts_pkg::FIFO_DEPTH - 2));
    assign wp1     = r_wp + 1'b1;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wp  = r_wp + mmts_pkg::FIFO_PTR_BITS'(i_push.cnt);
        n_rp  = pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + mmts_pkg::FIFO_CNT_BITS'(i_push.cnt)
                - mmts_pkg::FIFO_CNT_BITS'(pop);
    end

    // Result storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* src/maximal_munch_token_scanner.sv */
// Maximal-munch token scanner: one source byte per input transaction.
// Input channel: i_valid/o_ready with i_char_byte and i_is_last; is_last marks
// the final byte of a source text, after which offsets restart at zero.
// Output channel: o_valid/i_ready, one token, error or end marker per
// transaction; o_end_flag is set on the final result of each source text.
// A byte may produce zero, one or two results.
// A byte accepted into the input register is scanned as it leaves that
// register, and its results are written into the result queue, whose head
// drives the output. Throughput: one byte per cycle while each byte yields
// at most one result and the receiver is ready; the output side drains one
// result per cycle, so a byte with two results holds the output side longer.
// The input register and a four-entry result queue separate the two sides:
// bytes keep flowing while a result waits. When the receiver stalls, the
// queue fills and o_ready drops once fewer than two free entries remain.
// Reset (synchronous, active low) returns the scanner to its start state at
// offset zero and empties the input register and the result queue.
module maximal_munch_token_scanner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_char_byte,
    input  logic                              i_is_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mmts_pkg::KIND_BITS-1:0]    o_token_kind,
    output logic [mmts_pkg::VAL_BITS-1:0]     o_number_value,
    output logic [mmts_pkg::LEN_BITS-1:0]     o_lexeme_length,
    output logic [mmts_pkg::OFF_BITS-1:0]     o_start_offset,
    output logic [1:0]                        o_error_code,
    output logic                              o_end_flag
);

    logic                 r_in_v;
    logic [7:0]           r_char;
    logic                 r_last;
    logic                 room2;
    logic                 go;
    mmts_pkg::t_push      push;
    mmts_pkg::t_result    res;

    assign go      = r_in_v && room2;
    assign o_ready = !r_in_v || go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char_byte;
            r_last <= i_is_last;
        end
    end

    mmts_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_char  (r_char),
        .i_last  (r_last),
        .o_push  (push)
    );

    mmts_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_token_kind    = res.kind;
    assign o_number_value  = res.value;
    assign o_lexeme_length = res.length;
    assign o_start_offset  = res.start;
    assign o_error_code    = res.err;
    assign o_end_flag      = res.last;

endmodule
